>>> sv/ldwf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the per-row weak filter function for the luma deblocking filter
package ldwf_pkg;

	localparam int ROWS_DEFAULT = 4;
	localparam int ROW_FIELDS = 4;
	localparam int PIX_W = 8;
	localparam int ROW_IN_W = 6 * PIX_W;
	localparam int ROW_OUT_W = 4 * PIX_W;
	localparam int TC_W = 5;

	localparam int TAP_Q0P0 = 9;
	localparam int TAP_Q1P1 = 3;
	localparam int DELTA_RND = 8;
	localparam int DELTA_SHIFT = 4;
	localparam int THR_MULT = 10;

	typedef logic [ROW_IN_W-1:0] row_in_t;
	typedef logic [ROW_OUT_W-1:0] row_out_t;

	typedef struct packed {
		logic     filt;
		row_out_t pix;
	} row_res_t;

	// clamp a small signed value into a pixel
	function automatic logic [PIX_W-1:0] sat8(input logic signed [9:0] v);
		logic [PIX_W-1:0] r;
		if (v < 10'sd0) begin
			r = '0;
		end else if (v > 10'sd255) begin
			r = '1;
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

	// symmetric clip of v to -b..b
	function automatic logic signed [9:0] clip_sym(input logic signed [9:0] v,
			input logic signed [9:0] b);
		logic signed [9:0] r;
		if (v > b) begin
			r = b;
		end else if (v < -b) begin
			r = -b;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// weak filter on one row: p2 in the lowest byte, q2 in the highest
	function automatic row_res_t filter_row(input row_in_t w, input logic [TC_W-1:0] tc,
			input logic pe, input logic qe, input logic p1e, input logic q1e);
		logic signed [9:0]  p2, p1, p0, q0, q1, q2;
		logic signed [13:0] raw;
		logic signed [13:0] raw_sh;
		logic signed [9:0]  delta;
		logic [9:0]         ad;
		logic [8:0]         thr;
		logic signed [9:0]  tcs, tc2s, dc;
		logic signed [9:0]  avg_p, avg_q, dp, dq;
		logic [PIX_W-1:0]   np1, np0, nq0, nq1;
		row_res_t           res;
		p2 = $signed({2'b00, w[0*PIX_W +: PIX_W]});
		p1 = $signed({2'b00, w[1*PIX_W +: PIX_W]});
		p0 = $signed({2'b00, w[2*PIX_W +: PIX_W]});
		q0 = $signed({2'b00, w[3*PIX_W +: PIX_W]});
		q1 = $signed({2'b00, w[4*PIX_W +: PIX_W]});
		q2 = $signed({2'b00, w[5*PIX_W +: PIX_W]});
		raw = 14'(TAP_Q0P0) * 14'(q0 - p0) - 14'(TAP_Q1P1) * 14'(q1 - p1)
			+ 14'(DELTA_RND);
		raw_sh = raw >>> DELTA_SHIFT;
		delta = raw_sh[9:0];
		ad = (delta < 10'sd0) ? 10'(-delta) : 10'(delta);
		thr = 9'(tc) * 9'(THR_MULT);
		tcs = $signed({5'b00000, tc});
		tc2s = $signed({6'b000000, tc[TC_W-1:1]});
		dc = clip_sym(delta, tcs);
		avg_p = (p2 + p0 + 10'sd1) >>> 1;
		avg_q = (q2 + q0 + 10'sd1) >>> 1;
		dp = (avg_p - p1 + dc) >>> 1;
		dq = (avg_q - q1 - dc) >>> 1;
		np1 = p1[PIX_W-1:0];
		np0 = p0[PIX_W-1:0];
		nq0 = q0[PIX_W-1:0];
		nq1 = q1[PIX_W-1:0];
		res.filt = (ad < {1'b0, thr});
		if (res.filt) begin
			if (pe) begin
				np0 = sat8(p0 + dc);
			end
			if (qe) begin
				nq0 = sat8(q0 - dc);
			end
			if (p1e) begin
				np1 = sat8(p1 + clip_sym(dp, tc2s));
			end
			if (q1e) begin
				nq1 = sat8(q1 + clip_sym(dq, tc2s));
			end
		end
		res.pix = {nq1, nq0, np0, np1};
		return res;
	endfunction

endpackage

>>> sv/luma_deblock_weak_filter.sv
`timescale 1ns / 1ps
// luma deblocking weak filter: input word register, per-row filter logic, result register
//
// usage:
// - input channel (in_valid/in_ready) takes one word per edge segment: four rows of six
//   pixels p2..q2 across the edge, the clip strength tc and the p/q enable flags
// - output channel (out_valid/out_ready) returns one word per input word: new p1,p0,q0,q1
//   for each row and a mask of the rows that passed the delta threshold
// - the accepting edge loads the word into the input register, then the filter logic settles
//   into the result register, which drives out_valid
// - throughput is one word per clock while out_ready stays high; both register stages advance
//   together whenever the result register is empty or being drained
// - when the receiver stalls, the result register holds its word, the input register fills,
//   and in_ready drops only once both stages hold a word
// - reset clears both stage valid flags; payload registers are not reset
// - rows at or above ROWS pass their pixels through and report a zero mask bit
module luma_deblock_weak_filter #(
	parameter int ROWS = ldwf_pkg::ROWS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ldwf_pkg::row_in_t            row0_pixels,
	input  ldwf_pkg::row_in_t            row1_pixels,
	input  ldwf_pkg::row_in_t            row2_pixels,
	input  ldwf_pkg::row_in_t            row3_pixels,
	input  logic [ldwf_pkg::TC_W-1:0]    clip_limit,
	input  logic                         p_enable,
	input  logic                         q_enable,
	input  logic                         p_side_enable,
	input  logic                         q_side_enable,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ldwf_pkg::row_out_t           row0_out,
	output ldwf_pkg::row_out_t           row1_out,
	output ldwf_pkg::row_out_t           row2_out,
	output ldwf_pkg::row_out_t           row3_out,
	output logic [ldwf_pkg::ROW_FIELDS-1:0] rows_filtered
);
	import ldwf_pkg::*;

	// stage 1: registered input word
	logic                  valid_s1;
	row_in_t               rows_s1 [ROW_FIELDS];
	logic [TC_W-1:0]       tc_s1;
	logic                  pe_s1, qe_s1, p1e_s1, q1e_s1;

	// stage 2: registered result word
	logic                  valid_s2;
	row_out_t              rows_s2 [ROW_FIELDS];
	logic [ROW_FIELDS-1:0] filt_s2;

	logic                  adv_s1;
	logic                  take_in;
	row_res_t              res [ROW_FIELDS];

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			rows_s1[0] <= row0_pixels;
			rows_s1[1] <= row1_pixels;
			rows_s1[2] <= row2_pixels;
			rows_s1[3] <= row3_pixels;
			tc_s1      <= clip_limit;
			pe_s1      <= p_enable;
			qe_s1      <= q_enable;
			// side taps only count together with their main enable
			p1e_s1     <= p_enable && p_side_enable;
			q1e_s1     <= q_enable && q_side_enable;
		end
	end

	// per-row filter, rows are independent
	for (genvar i = 0; i < ROW_FIELDS; i++) begin : g_row
		if (i < ROWS) begin : g_filt
			assign res[i] = filter_row(rows_s1[i], tc_s1, pe_s1, qe_s1, p1e_s1, q1e_s1);
		end else begin : g_pass
			// unprocessed row: p1,p0,q0,q1 straight through
			assign res[i].filt = 1'b0;
			assign res[i].pix  = rows_s1[i][PIX_W +: ROW_OUT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			for (int k = 0; k < ROW_FIELDS; k++) begin
				rows_s2[k] <= res[k].pix;
				filt_s2[k] <= res[k].filt;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign row0_out      = rows_s2[0];
	assign row1_out      = rows_s2[1];
	assign row2_out      = rows_s2[2];
	assign row3_out      = rows_s2[3];
	assign rows_filtered = filt_s2;

endmodule
